// File: hw/rtl/nslr_pkg.sv
package nslr_pkg;

    localparam int NOTE_COUNT_DEF = 128;
    localparam int TIME_BITS_DEF  = 32;
    localparam int NOTES_MAX      = 128;

    localparam int TIME_W   = 32;
    localparam int NOTE_W   = 7;
    localparam int LEVEL_W  = 10;
    localparam int PERIOD_W = 17;
    localparam int HALF_W   = 16;
    localparam int CHK_W    = 20;
    localparam int HOLD_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHK_W-1:0]  CHECK_PERIOD_RST = 20'd20000;
    localparam logic [CHK_W-1:0]  CHECK_HALF_RST   = 20'd10000;
    localparam logic [HOLD_W-1:0] HOLDOFF_RST      = 32'd500000;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_NONE     = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHECK_PERIOD = 2'd0,
        REG_CHECK_HALF   = 2'd1,
        REG_HOLDOFF      = 2'd2,
        REG_UNUSED       = 2'd3
    } cfg_idx_t;

    // step period in us per MIDI note: trunc(1e6 / note frequency)
    localparam logic [PERIOD_W-1:0] PERIOD_ROM [NOTES_MAX] = '{
        122312, 115447, 108967, 102851, 97079, 91630, 86487, 81633, 77051, 72727, 68645, 64792,
        61156, 57723, 54483, 51425, 48539, 45815, 43243, 40816, 38525, 36363, 34322, 32396,
        30578, 28861, 27241, 25712, 24269, 22907, 21621, 20408, 19262, 18181, 17161, 16198,
        15289, 14430, 13620, 12856, 12134, 11453, 10810, 10204, 9631, 9090, 8580, 8099,
        7644, 7215, 6810, 6428, 6067, 5726, 5405, 5102, 4815, 4545, 4290, 4049,
        3822, 3607, 3405, 3214, 3033, 2863, 2702, 2551, 2407, 2272, 2145, 2024,
        1911, 1803, 1702, 1607, 1516, 1431, 1351, 1275, 1203, 1136, 1072, 1012,
        955, 901, 851, 803, 758, 715, 675, 637, 601, 568, 536, 506,
        477, 450, 425, 401, 379, 357, 337, 318, 300, 284, 268, 253,
        238, 225, 212, 200, 189, 178, 168, 159, 150, 142, 134, 126,
        119, 112, 106, 100, 94, 89, 84, 79
    };

endpackage

// File: hw/rtl/note_stepper_with_limit_reverse.sv
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    op, note, time_us, limit_level
// out      source     out_valid / out_stall  step_out, dir_out, relay_out, enable_out
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Note on, note off, unknown op and ticks while silent go from accept straight to S_EMIT, which loads the result.
// A sounding tick divides the low TB bits of time, TB = min(TIME_BITS, 32): one restoring
// divider, one quotient bit per cycle, runs time mod step period, then time mod check period.
// A zero check period skips the second pass.
// Reset (rst_n, asynchronous) clears all state and loads the register defaults.
// One item at a time; the next item is taken while a result waits under out_stall.
module note_stepper_with_limit_reverse
    import nslr_pkg::*;
#(
    parameter int NOTE_COUNT = NOTE_COUNT_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           op,
    input  logic [NOTE_W-1:0]    note,
    input  logic [TIME_W-1:0]    time_us,
    input  logic [LEVEL_W-1:0]   limit_level,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 step_out,
    output logic                 dir_out,
    output logic                 relay_out,
    output logic                 enable_out,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int TW    = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int CNT_W = $clog2(TW);
    localparam int XW    = (TW > CHK_W) ? TW : CHK_W;
    localparam logic [7:0] NOTE_LIM = 8'(NOTE_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_STEP,
        S_DIV_CHECK,
        S_EMIT
    } state_t;

    state_t              state_reg;

    logic [CHK_W-1:0]    chk_period_reg;
    logic [CHK_W-1:0]    chk_half_reg;
    logic [HOLD_W-1:0]   holdoff_us_reg;

    logic [PERIOD_W-1:0] period_reg;
    logic [HALF_W-1:0]   half_reg;
    logic                step_level_reg;
    logic                dir_reg;
    logic                chk_phase_reg;
    logic                relay_reg;
    logic [TW-1:0]       holdoff_until_reg;
    logic                enabled_reg;

    logic [TW-1:0]       t_reg;
    logic                lim_zero_reg;
    logic [CHK_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic                out_valid_reg;
    logic                step_out_reg;
    logic                dir_out_reg;
    logic                relay_out_reg;
    logic                enable_out_reg;

    // shared restoring-divider step
    logic [CHK_W-1:0]    div_d;
    logic [CHK_W:0]      trial;
    logic                trial_ge;
    logic [CHK_W-1:0]    rem_next;
    logic                last_bit;
    logic                step_want;
    logic                chk_want;
    logic                chk_apply;
    logic                chk_fire;
    logic [TW-1:0]       holdoff_next;
    logic                in_take;
    logic                out_take;
    logic                out_load;

    assign in_stall   = (state_reg != S_IDLE);
    assign in_take    = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign cfg_ready  = 1'b1;

    assign out_valid  = out_valid_reg;
    assign step_out   = step_out_reg;
    assign dir_out    = dir_out_reg;
    assign relay_out  = relay_out_reg;
    assign enable_out = enable_out_reg;

    always_comb
    begin
        div_d     = (state_reg == S_DIV_STEP) ? CHK_W'(period_reg) : chk_period_reg;
        trial     = {rem_reg, t_reg[cnt_reg]};
        trial_ge  = (trial >= {1'b0, div_d});
        rem_next  = trial_ge ? CHK_W'(trial - {1'b0, div_d}) : trial[CHK_W-1:0];
        last_bit  = (cnt_reg == '0);
        step_want = (rem_next <= CHK_W'(half_reg));
        // zero check period: remainder is the time itself
        chk_want  = (state_reg == S_DIV_CHECK) ? (rem_next <= chk_half_reg)
                                               : (XW'(t_reg) <= XW'(chk_half_reg));
        chk_apply = last_bit && ((state_reg == S_DIV_CHECK) ||
                    (state_reg == S_DIV_STEP && chk_period_reg == '0));
        chk_fire  = chk_want && !chk_phase_reg && (t_reg > holdoff_until_reg) && lim_zero_reg;
        holdoff_next = t_reg + holdoff_us_reg[TW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            chk_period_reg    <= CHECK_PERIOD_RST;
            chk_half_reg      <= CHECK_HALF_RST;
            holdoff_us_reg    <= HOLDOFF_RST;
            period_reg        <= '0;
            half_reg          <= '0;
            step_level_reg    <= 1'b0;
            dir_reg           <= 1'b0;
            chk_phase_reg     <= 1'b0;
            relay_reg         <= 1'b0;
            holdoff_until_reg <= '0;
            enabled_reg       <= 1'b0;
            t_reg             <= '0;
            lim_zero_reg      <= 1'b0;
            rem_reg           <= '0;
            out_valid_reg     <= 1'b0;
            step_out_reg      <= 1'b0;
            dir_out_reg       <= 1'b0;
            relay_out_reg     <= 1'b0;
            enable_out_reg    <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    REG_CHECK_PERIOD: chk_period_reg <= cfg_data[CHK_W-1:0];
                    REG_CHECK_HALF:   chk_half_reg   <= cfg_data[CHK_W-1:0];
                    REG_HOLDOFF:      holdoff_us_reg <= cfg_data[HOLD_W-1:0];
                    REG_UNUSED:       ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                step_out_reg   <= step_level_reg;
                dir_out_reg    <= dir_reg;
                relay_out_reg  <= relay_reg;
                enable_out_reg <= enabled_reg;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        t_reg        <= time_us[TW-1:0];
                        lim_zero_reg <= (limit_level == '0);
                        rem_reg      <= '0;
                        cnt_reg      <= CNT_W'(TW - 1);
                        state_reg    <= (op_t'(op) == OP_TICK && period_reg != '0) ?
                                        S_DIV_STEP : S_EMIT;
                        unique case (op_t'(op))
                            OP_NOTE_ON:
                            begin
                                if ({1'b0, note} < NOTE_LIM)
                                begin
                                    period_reg        <= PERIOD_ROM[note];
                                    half_reg          <= PERIOD_ROM[note][PERIOD_W-1:1];
                                    holdoff_until_reg <= '0;
                                    enabled_reg       <= 1'b1;
                                end
                            end
                            OP_NOTE_OFF:
                            begin
                                period_reg        <= '0;
                                half_reg          <= '0;
                                chk_phase_reg     <= 1'b0;
                                holdoff_until_reg <= '0;
                                enabled_reg       <= 1'b0;
                            end
                            OP_TICK: ;
                            OP_NONE: ;
                        endcase
                    end
                end
                S_DIV_STEP, S_DIV_CHECK:
                begin
                    if (last_bit)
                    begin
                        rem_reg <= '0;
                        cnt_reg <= CNT_W'(TW - 1);
                        if (state_reg == S_DIV_STEP)
                        begin
                            if (step_want != step_level_reg)
                            begin
                                step_level_reg <= step_want;
                                if (!step_want)
                                begin
                                    dir_reg <= ~dir_reg;
                                end
                            end
                            state_reg <= (chk_period_reg == '0) ? S_EMIT : S_DIV_CHECK;
                        end
                        else
                        begin
                            state_reg <= S_EMIT;
                        end
                        if (chk_apply && chk_want != chk_phase_reg)
                        begin
                            chk_phase_reg <= chk_want;
                            if (chk_fire)
                            begin
                                relay_reg         <= ~relay_reg;
                                holdoff_until_reg <= holdoff_next;
                            end
                        end
                    end
                    else
                    begin
                        rem_reg <= rem_next;
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_enable_period: assert property (@(posedge clk) disable iff (!rst_n)
        enabled_reg == (period_reg != '0))
        else $error("enable out of step with period");

    a_half_period: assert property (@(posedge clk) disable iff (!rst_n)
        half_reg == period_reg[PERIOD_W-1:1])
        else $error("half period mismatch");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DIV_STEP || state_reg == S_DIV_CHECK) && div_d != '0)
        |-> (rem_reg < div_d))
        else $error("partial remainder not below divisor");

    a_step_pass_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_STEP && last_bit) |=> (state_reg != S_DIV_STEP))
        else $error("step division ran past last bit");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("result not presented");
`endif

endmodule
